// ----- design/owmb_pkg.sv -----
// ----------------------------------------------------------------------------
// owmb_pkg
// Shared types, codes and defaults for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owmb_pkg;

    // timer width default and configuration word shape
    localparam int TIMER_WIDTH_DEF = 10;
    localparam int CFG_W           = 10;
    localparam int NUM_CFG         = 7;
    localparam int CFG_IDX_W       = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd6;

    typedef logic [CFG_W-1:0] t_cfg_word;
    typedef t_cfg_word [NUM_CFG-1:0] t_cfg_bank;

    // register values after reset, in ticks
    localparam t_cfg_bank CFG_DEFAULTS = {
        10'd45,   // read tail
        10'd14,   // read sample
        10'd60,   // write hold
        10'd1,    // slot start
        10'd420,  // reset tail
        10'd60,   // presence wait
        10'd480   // reset low
    };

    // command codes on the input channel
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_RST_LOW    = 3'd1,
        PH_RST_WAIT   = 3'd2,
        PH_RST_TAIL   = 3'd3,
        PH_SLOT_START = 3'd4,
        PH_WR_HOLD    = 3'd5,
        PH_RD_WAIT    = 3'd6,
        PH_RD_TAIL    = 3'd7
    } t_phase;

    // one result beat
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       no_presence;
        logic [7:0] read_byte;
        logic       rejected;
    } t_result;

endpackage

// ----- design/owmb_if.sv -----
// ----------------------------------------------------------------------------
// owmb interfaces
// Command, result and configuration channels of the 1-Wire bus master.
// ----------------------------------------------------------------------------
interface owmb_cmd_if import owmb_pkg::*; ();
    logic       valid;
    logic       ready;
    t_op        op;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output op, output data_byte, output line_level,
                    input ready);
    modport sink   (input valid, input op, input data_byte, input line_level,
                    output ready);
endinterface

interface owmb_res_if import owmb_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       no_presence;
    logic [7:0] read_byte;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output no_presence, output read_byte, output rejected,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input no_presence, input read_byte, input rejected,
                    output ready);
endinterface

interface owmb_cfg_if import owmb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/owmb_cfg.sv -----
// ----------------------------------------------------------------------------
// owmb_cfg
// Timing register bank, written through the configuration channel.
// ----------------------------------------------------------------------------
module owmb_cfg import owmb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    owmb_cfg_if.sink   i_cfg,
    output t_cfg_bank  o_cfg
);

    t_cfg_bank r_cfg;

    // writes are taken whenever out of reset
    assign i_cfg.ready = i_rst_n;

    // register bank, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_DEFAULTS;
        end else if (i_cfg.valid) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                if (i_cfg.index == CFG_IDX_W'(i)) begin
                    r_cfg[i] <= i_cfg.data;
                end
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/owmb_ctrl.sv -----
// ----------------------------------------------------------------------------
// owmb_ctrl
// Reset, write-slot and read-slot sequencer, one step per accepted beat.
// ----------------------------------------------------------------------------
module owmb_ctrl import owmb_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_op        i_op,
    input  logic [7:0] i_data_byte,
    input  logic       i_line_level,
    input  t_cfg_bank  i_cfg,
    output t_result    o_result,
    output logic       o_idle
);

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    t_phase                 r_phase,     n_phase;
    t_op                    r_cmd,       n_cmd;
    logic [TIMER_WIDTH-1:0] r_tick,      n_tick;
    logic [2:0]             r_bit,       n_bit;
    logic [7:0]             r_shift,     n_shift;
    logic                   r_presence,  n_presence;
    logic [7:0]             r_last_read, n_last_read;
    logic                   r_drive,     n_drive;

    logic [TIMER_WIDTH-1:0] tick_inc;
    t_cfg_word              cfg_sel;
    logic                   count_done;
    logic                   done;
    logic                   rejected;

    // saturating tick count and phase-end compare
    assign tick_inc = (r_tick != TIMER_MAX) ? r_tick + 1'b1 : r_tick;

    always_comb begin
        case (r_phase)
            PH_RST_LOW:    cfg_sel = i_cfg[CFG_RESET_LOW];
            PH_RST_WAIT:   cfg_sel = i_cfg[CFG_PRESENCE_WAIT];
            PH_RST_TAIL:   cfg_sel = i_cfg[CFG_RESET_TAIL];
            PH_SLOT_START: cfg_sel = i_cfg[CFG_SLOT_START];
            PH_WR_HOLD:    cfg_sel = i_cfg[CFG_WRITE_HOLD];
            PH_RD_WAIT:    cfg_sel = i_cfg[CFG_READ_SAMPLE];
            PH_RD_TAIL:    cfg_sel = i_cfg[CFG_READ_TAIL];
            default:       cfg_sel = '0;
        endcase
    end

    assign count_done = (CMP_W'(tick_inc) >= CMP_W'(cfg_sel)) || (tick_inc == TIMER_MAX);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cmd       <= OP_TICK;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_last_read <= '0;
            r_drive     <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_presence  <= n_presence;
            r_last_read <= n_last_read;
            r_drive     <= n_drive;
        end
    end

    // next state for one beat
    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_presence  = r_presence;
        n_last_read = r_last_read;
        n_drive     = r_drive;
        done        = 1'b0;
        rejected    = 1'b0;

        if (i_op != OP_TICK) begin
            // command beat: start when idle, refuse otherwise
            if (r_phase != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                n_cmd   = i_op;
                n_tick  = '0;
                n_bit   = '0;
                n_drive = 1'b1;
                if (i_op == OP_RESET) begin
                    n_phase = PH_RST_LOW;
                end else begin
                    n_shift = (i_op == OP_WRITE) ? i_data_byte : 8'h00;
                    n_phase = PH_SLOT_START;
                end
            end
        end else begin
            case (r_phase)
                PH_RST_LOW: begin
                    n_tick = tick_inc;
                    if (count_done) begin
                        n_phase = PH_RST_WAIT;
                        n_tick  = '0;
                        n_drive = 1'b0;
                    end
                end
                PH_RST_WAIT: begin
                    n_tick = tick_inc;
                    if (count_done) begin
                        n_presence = i_line_level;
                        n_phase    = PH_RST_TAIL;
                        n_tick     = '0;
                    end
                end
                PH_RST_TAIL: begin
                    n_tick = tick_inc;
                    if (count_done) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        done    = 1'b1;
                    end
                end
                PH_SLOT_START: begin
                    if (!r_drive) begin
                        // recovery tick over, slot begins
                        n_drive = 1'b1;
                        n_tick  = '0;
                    end else begin
                        n_tick = tick_inc;
                        if (count_done) begin
                            n_tick = '0;
                            if (r_cmd == OP_WRITE) begin
                                n_phase = PH_WR_HOLD;
                                n_drive = ~r_shift[0];
                            end else begin
                                n_phase = PH_RD_WAIT;
                                n_drive = 1'b0;
                            end
                        end
                    end
                end
                PH_WR_HOLD: begin
                    n_tick = tick_inc;
                    if (count_done) begin
                        n_shift = {1'b0, r_shift[7:1]};
                        n_tick  = '0;
                        n_drive = 1'b0;
                        if (r_bit == 3'd7) begin
                            n_bit   = '0;
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_SLOT_START;
                        end
                    end
                end
                PH_RD_WAIT: begin
                    n_tick = tick_inc;
                    if (count_done) begin
                        n_shift = {i_line_level, r_shift[7:1]};
                        n_phase = PH_RD_TAIL;
                        n_tick  = '0;
                    end
                end
                PH_RD_TAIL: begin
                    n_tick = tick_inc;
                    if (count_done) begin
                        n_tick  = '0;
                        n_drive = 1'b0;
                        if (r_bit == 3'd7) begin
                            n_bit       = '0;
                            n_phase     = PH_IDLE;
                            n_last_read = r_shift;
                            done        = 1'b1;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_SLOT_START;
                        end
                    end
                end
                default: begin
                    // idle tick: bus released
                    n_drive = 1'b0;
                end
            endcase
        end
    end

    // result of this beat
    always_comb begin
        o_result.drive_low   = n_drive;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.no_presence = n_presence;
        o_result.read_byte   = n_last_read;
        o_result.rejected    = rejected;
    end

    assign o_idle = (r_phase == PH_IDLE);

endmodule

// ----- design/owmb_out.sv -----
// ----------------------------------------------------------------------------
// owmb_out
// Result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module owmb_out import owmb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_ready,
    owmb_res_if.source  o_res
);

    logic    r_valid;
    t_result r_result;

    // room when empty or the held beat leaves this cycle
    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.drive_low   = r_result.drive_low;
    assign o_res.busy_res    = r_result.busy_res;
    assign o_res.done_res    = r_result.done_res;
    assign o_res.no_presence = r_result.no_presence;
    assign o_res.read_byte   = r_result.read_byte;
    assign o_res.rejected    = r_result.rejected;

endmodule

// ----- design/one_wire_bus_master.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by microsecond tick beats and command beats.
// ----------------------------------------------------------------------------
// every beat, tick or command, yields its result beat from the result register in the cycle after it is taken
// throughput: one beat per cycle, limited only by the result register draining
// the sequencer state updates in the same cycle a beat is taken
// reset: synchronous active low; timing registers return to defaults, bus released
// ----------------------------------------------------------------------------
module one_wire_bus_master import owmb_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    owmb_cmd_if.sink    i_cmd,
    owmb_cfg_if.sink    i_cfg,
    owmb_res_if.source  o_res
);

    t_cfg_bank cfg;
    t_result   result;
    logic      out_ready;
    logic      step;
    logic      ctrl_idle;

    // a beat is taken whenever the result register has room, out of reset
    assign i_cmd.ready = out_ready && i_rst_n;
    assign step        = i_cmd.valid && i_cmd.ready;

    owmb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    owmb_ctrl #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_op         (i_cmd.op),
        .i_data_byte  (i_cmd.data_byte),
        .i_line_level (i_cmd.line_level),
        .i_cfg        (cfg),
        .o_result     (result),
        .o_idle       (ctrl_idle)
    );

    owmb_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (result),
        .o_ready  (out_ready),
        .o_res    (o_res)
    );

    // a finished command leaves the sequencer idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.done_res && o_res.busy_res))
        else $error("done and busy reported together");

    // a tick while idle gives a released, idle result
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && ctrl_idle && i_cmd.op == OP_TICK) |=>
            (o_res.valid && !o_res.drive_low && !o_res.busy_res && !o_res.rejected))
        else $error("idle tick gave an active result");

    // an empty result register never stalls the command side
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_cmd.ready)
        else $error("command stalled with empty result register");

endmodule
